/* hw/rtl/pipqa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipqa_pkg: shared types, constants and helpers for the quadrant-angle test
// Coordinate widths, quadrant codes, angle saturation and the bundle that
// carries one item's edge deltas from the edge stage to the accumulator.
// ----------------------------------------------------------------------------
package pipqa_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int ANGLE_W = 16;
  localparam int DELTA_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [1:0]                quad_t;

  // Quadrants relative to the test point.
  localparam quad_t QUAD_NE = 2'd0;
  localparam quad_t QUAD_NW = 2'd1;
  localparam quad_t QUAD_SW = 2'd2;
  localparam quad_t QUAD_SE = 2'd3;

  localparam delta_t DQ_WRAP_POS = 3'sd3;
  localparam delta_t DQ_WRAP_NEG = -3'sd3;
  localparam delta_t DQ_HALF_POS = 3'sd2;
  localparam delta_t DQ_HALF_NEG = -3'sd2;
  localparam delta_t DQ_ONE_POS  = 3'sd1;
  localparam delta_t DQ_ONE_NEG  = -3'sd1;

  localparam angle_t ANGLE_ZERO    = '0;
  localparam angle_t ANGLE_MAX     = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam angle_t ANGLE_MIN     = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam angle_t ANGLE_TURN_CW = ANGLE_W'(-4);
  localparam angle_t ANGLE_TURN_CC = ANGLE_W'(4);

  typedef struct packed {
    logic   first;
    logic   last;
    delta_t d_edge;
    delta_t d_close;
  } edge_pair_t;

  function automatic quad_t quad_of(coord_t x, coord_t y, coord_t tx, coord_t ty);
    quad_t q;
    if (x > tx) begin
      q = (y > ty) ? QUAD_NE : QUAD_SE;
    end else begin
      q = (y > ty) ? QUAD_NW : QUAD_SW;
    end
    return q;
  endfunction

  function automatic angle_t sat_add(angle_t acc, delta_t d);
    logic signed [ANGLE_W:0] s;
    angle_t r;
    s = {acc[ANGLE_W-1], acc} + {{(ANGLE_W+1-DELTA_W){d[DELTA_W-1]}}, d};
    if (s[ANGLE_W] != s[ANGLE_W-1]) begin
      r = s[ANGLE_W] ? ANGLE_MIN : ANGLE_MAX;
    end else begin
      r = s[ANGLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/point_in_polygon_quadrant_angle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_quadrant_angle: streaming quadrant-angle inside test
// Takes polygon vertices one per transfer and reports, on the last vertex,
// whether the test point lies inside and the summed quadrant angle.
// ----------------------------------------------------------------------------
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+-----------------------------------------
//  vertex   | in_valid_i / in_ready_o | vertex_x/y_i, point_x/y_i, last_vertex_i
//  result   | out_valid_o/out_ready_i | inside_res_o, angle_sum_o
//
// One vertex per cycle is accepted unless a stalled result holds the pipeline;
// a last vertex passes the input register, edge stage, then result register.
// The edge stage holds both edge evaluations for the vertex: the edge from the
// previous vertex and, on the last vertex, the closing edge.
// Reset clears the pipeline and arms the next vertex as the first of a polygon.
// A stalled result holds the pipeline only behind a last vertex; other vertices
// keep draining into the angle sum.
// ----------------------------------------------------------------------------
module point_in_polygon_quadrant_angle (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pipqa_pkg::coord_t vertex_x_i,
  input  pipqa_pkg::coord_t vertex_y_i,
  input  pipqa_pkg::coord_t point_x_i,
  input  pipqa_pkg::coord_t point_y_i,
  input  logic              last_vertex_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              inside_res_o,
  output pipqa_pkg::angle_t angle_sum_o
);

  // Input register.
  logic              s0_valid_q;
  pipqa_pkg::coord_t s0_vx_q, s0_vy_q, s0_px_q, s0_py_q;
  logic              s0_last_q;
  logic              s0_fire;

  // Polygon state, advanced as each vertex leaves the input register.
  logic              awaiting_first_q;
  pipqa_pkg::coord_t test_x_q, test_y_q;
  pipqa_pkg::coord_t first_x_q, first_y_q;
  pipqa_pkg::quad_t  first_quad_q;
  pipqa_pkg::coord_t prev_x_q, prev_y_q;
  pipqa_pkg::quad_t  prev_quad_q;

  // Edge stage register.
  logic                  s1_valid_q;
  pipqa_pkg::edge_pair_t s1_q, s1_d;
  logic                  s1_ready;
  logic                  s1_accept;

  pipqa_pkg::coord_t tx, ty, fx, fy;
  pipqa_pkg::quad_t  q_cur, fq;
  pipqa_pkg::delta_t d_prev, d_close;

  assign s1_accept  = !s1_valid_q || s1_ready;
  assign s0_fire    = s0_valid_q && s1_accept;
  assign in_ready_o = !s0_valid_q || s1_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_vx_q   <= vertex_x_i;
      s0_vy_q   <= vertex_y_i;
      s0_px_q   <= point_x_i;
      s0_py_q   <= point_y_i;
      s0_last_q <= last_vertex_i;
    end
  end

  // The first vertex of a polygon supplies the test point and the first vertex.
  assign tx    = awaiting_first_q ? s0_px_q : test_x_q;
  assign ty    = awaiting_first_q ? s0_py_q : test_y_q;
  assign q_cur = pipqa_pkg::quad_of(s0_vx_q, s0_vy_q, tx, ty);
  assign fx    = awaiting_first_q ? s0_vx_q : first_x_q;
  assign fy    = awaiting_first_q ? s0_vy_q : first_y_q;
  assign fq    = awaiting_first_q ? q_cur : first_quad_q;

  pipqa_edge u_edge_prev (
    .x1_i    (prev_x_q),
    .y1_i    (prev_y_q),
    .q1_i    (prev_quad_q),
    .x2_i    (s0_vx_q),
    .y2_i    (s0_vy_q),
    .q2_i    (q_cur),
    .tx_i    (tx),
    .ty_i    (ty),
    .delta_o (d_prev)
  );

  pipqa_edge u_edge_close (
    .x1_i    (s0_vx_q),
    .y1_i    (s0_vy_q),
    .q1_i    (q_cur),
    .x2_i    (fx),
    .y2_i    (fy),
    .q2_i    (fq),
    .tx_i    (tx),
    .ty_i    (ty),
    .delta_o (d_close)
  );

  always_comb begin
    s1_d.first   = awaiting_first_q;
    s1_d.last    = s0_last_q;
    s1_d.d_edge  = awaiting_first_q ? '0 : d_prev;
    s1_d.d_close = s0_last_q ? d_close : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_first_q <= 1'b1;
      s1_valid_q       <= 1'b0;
    end else begin
      if (s0_fire) begin
        awaiting_first_q <= s0_last_q;
      end
      if (s1_accept) begin
        s1_valid_q <= s0_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_fire) begin
      s1_q        <= s1_d;
      prev_x_q    <= s0_vx_q;
      prev_y_q    <= s0_vy_q;
      prev_quad_q <= q_cur;
      if (awaiting_first_q) begin
        test_x_q     <= s0_px_q;
        test_y_q     <= s0_py_q;
        first_x_q    <= s0_vx_q;
        first_y_q    <= s0_vy_q;
        first_quad_q <= q_cur;
      end
    end
  end

  pipqa_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid_q),
    .s1_i         (s1_q),
    .s1_ready_o   (s1_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o),
    .angle_sum_o  (angle_sum_o)
  );

endmodule

/* hw/rtl/pipqa_edge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipqa_edge: angle change of one polygon edge
// Wraps the quadrant difference and, for a half turn, decides the crossing
// side with an exact cross-multiplication compare.
// ----------------------------------------------------------------------------
module pipqa_edge (
  input  pipqa_pkg::coord_t x1_i,
  input  pipqa_pkg::coord_t y1_i,
  input  pipqa_pkg::quad_t  q1_i,
  input  pipqa_pkg::coord_t x2_i,
  input  pipqa_pkg::coord_t y2_i,
  input  pipqa_pkg::quad_t  q2_i,
  input  pipqa_pkg::coord_t tx_i,
  input  pipqa_pkg::coord_t ty_i,
  output pipqa_pkg::delta_t delta_o
);

  pipqa_pkg::delta_t dq;
  pipqa_pkg::diff_t  dy;
  pipqa_pkg::diff_t  dx12;
  pipqa_pkg::diff_t  ex;
  pipqa_pkg::diff_t  ey;
  pipqa_pkg::prod_t  prod_a;
  pipqa_pkg::prod_t  prod_b;
  logic              right;

  assign dq   = $signed({1'b0, q2_i}) - $signed({1'b0, q1_i});
  assign dy   = pipqa_pkg::diff_t'(y1_i) - pipqa_pkg::diff_t'(y2_i);
  assign dx12 = pipqa_pkg::diff_t'(x1_i) - pipqa_pkg::diff_t'(x2_i);
  assign ex   = pipqa_pkg::diff_t'(x2_i) - pipqa_pkg::diff_t'(tx_i);
  assign ey   = pipqa_pkg::diff_t'(y2_i) - pipqa_pkg::diff_t'(ty_i);

  // The intercept lies right of the test point when (x2-px)*dy and
  // (y2-py)*(x1-x2) differ in the direction given by the sign of dy.
  assign prod_a = pipqa_pkg::prod_t'(ex) * pipqa_pkg::prod_t'(dy);
  assign prod_b = pipqa_pkg::prod_t'(ey) * pipqa_pkg::prod_t'(dx12);
  assign right  = (dy > 0) ? (prod_a > prod_b) : (prod_a < prod_b);

  always_comb begin
    delta_o = dq;
    if (dq == pipqa_pkg::DQ_WRAP_POS) begin
      delta_o = pipqa_pkg::DQ_ONE_NEG;
    end else if (dq == pipqa_pkg::DQ_WRAP_NEG) begin
      delta_o = pipqa_pkg::DQ_ONE_POS;
    end else if ((dq == pipqa_pkg::DQ_HALF_POS || dq == pipqa_pkg::DQ_HALF_NEG) && right) begin
      delta_o = -dq;
    end
  end

endmodule

/* hw/rtl/pipqa_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipqa_accum: angle accumulator and result register
// Adds an item's edge deltas to the saturating angle sum and, on the last
// vertex, loads the inside flag and the final sum into the output register.
// ----------------------------------------------------------------------------
module pipqa_accum (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s1_valid_i,
  input  pipqa_pkg::edge_pair_t  s1_i,
  output logic                   s1_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   inside_res_o,
  output pipqa_pkg::angle_t      angle_sum_o
);

  pipqa_pkg::angle_t acc_q, acc_d;
  pipqa_pkg::angle_t base;
  pipqa_pkg::angle_t sum_edge;
  pipqa_pkg::angle_t sum_close;
  logic              out_valid_q;
  logic              inside_q;
  pipqa_pkg::angle_t angle_q;
  logic              out_free;
  logic              s1_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  // An item that closes no polygon only updates the sum and never waits.
  assign s1_ready_o = !s1_i.last || out_free;
  assign s1_fire    = s1_valid_i && s1_ready_o;

  assign base      = s1_i.first ? pipqa_pkg::ANGLE_ZERO : acc_q;
  assign sum_edge  = pipqa_pkg::sat_add(base, s1_i.d_edge);
  assign sum_close = pipqa_pkg::sat_add(sum_edge, s1_i.d_close);
  assign acc_d     = s1_i.last ? sum_close : sum_edge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= pipqa_pkg::ANGLE_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        acc_q <= acc_d;
      end
      if (s1_fire && s1_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_i.last) begin
      angle_q  <= sum_close;
      inside_q <= (sum_close == pipqa_pkg::ANGLE_TURN_CC) ||
                  (sum_close == pipqa_pkg::ANGLE_TURN_CW);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign angle_sum_o  = angle_q;

endmodule

/* hw/rtl/pipqa_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipqa_chk: port-level checks for the quadrant-angle block
// Tracks closing vertices in flight and checks results against them and
// against the inside flag rule.
// ----------------------------------------------------------------------------
module pipqa_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              last_vertex_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              inside_res_o,
  input pipqa_pkg::angle_t angle_sum_o
);

  logic [2:0] pending_q, pending_d;
  logic       in_last_xfer;
  logic       out_xfer;

  assign in_last_xfer = in_valid_i && in_ready_o && last_vertex_i;
  assign out_xfer     = out_valid_o && out_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_last_xfer && !out_xfer) begin
      pending_d = pending_q + 3'd1;
    end else if (!in_last_xfer && out_xfer) begin
      pending_d = pending_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // Every result transfer belongs to an earlier closing vertex.
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != 3'd0))
    else $error("result shown without a pending closing vertex");

  // Input register, edge stage and result register hold at most three polygons.
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more closing vertices in flight than pipeline stages");

  a_inside_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inside_res_o == ((angle_sum_o == pipqa_pkg::ANGLE_TURN_CC) ||
                                      (angle_sum_o == pipqa_pkg::ANGLE_TURN_CW))))
    else $error("inside flag disagrees with the angle sum");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result withdrawn before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(angle_sum_o) && $stable(inside_res_o)))
    else $error("result changed while stalled");

endmodule

bind point_in_polygon_quadrant_angle pipqa_chk u_pipqa_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .last_vertex_i (last_vertex_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .inside_res_o  (inside_res_o),
  .angle_sum_o   (angle_sum_o)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for point_in_polygon_quadrant_angle
// Streams directed and random polygons through the vertex channel, predicts
// the quadrant-angle sum and the inside flag of every polygon, and compares
// each result transfer against the oldest prediction. Both channels idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import pipqa_pkg::*;

  localparam int          WRAP_STEP   = 3;
  localparam int          HALF_TURN   = 2;
  localparam int          HOLD_AFTER  = 25;
  localparam int          HOLD_CYCLES = 400;
  localparam int          WIND_TURNS  = 3;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // Tracks the polygon being streamed and keeps the predicted results in order.
  class polygon_scoreboard;
    typedef struct {
      logic   in_poly;
      angle_t sum;
    } verdict_t;

    bit       awaiting_first;
    longint   test_x, test_y, first_x, first_y, prev_x, prev_y;
    quad_t    first_quad, prev_quad;
    int       angle;
    verdict_t expected_verdicts[$];
    int       mismatches;
    int       results_checked;

    function new();
      awaiting_first  = 1'b1;
      test_x          = 0;
      test_y          = 0;
      first_x         = 0;
      first_y         = 0;
      prev_x          = 0;
      prev_y          = 0;
      first_quad      = QUAD_NE;
      prev_quad       = QUAD_NE;
      angle           = 0;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function quad_t quadrant(longint x, longint y);
      if (x > test_x) begin
        return (y > test_y) ? QUAD_NE : QUAD_SE;
      end
      return (y > test_y) ? QUAD_NW : QUAD_SW;
    endfunction

    function int edge_turn(longint x1, longint y1, quad_t q1,
                           longint x2, longint y2, quad_t q2);
      int     d;
      longint dy, lhs, rhs;
      bit     right;
      d = int'(q2) - int'(q1);
      if (d == WRAP_STEP) return -1;
      if (d == -WRAP_STEP) return 1;
      if (d == HALF_TURN || d == -HALF_TURN) begin
        // The crossing at the test point's y lies to its right: flip the half turn.
        dy    = y1 - y2;
        lhs   = (x2 - test_x) * dy;
        rhs   = (y2 - test_y) * (x1 - x2);
        right = (dy > 0) ? (lhs > rhs) : (lhs < rhs);
        if (right) d = -d;
      end
      return d;
    endfunction

    function void accumulate(int d);
      angle = angle + d;
      if (angle > int'(ANGLE_MAX)) angle = int'(ANGLE_MAX);
      if (angle < int'(ANGLE_MIN)) angle = int'(ANGLE_MIN);
    endfunction

    function void note_vertex(coord_t vx, coord_t vy, coord_t px, coord_t py, logic last);
      longint   x, y;
      quad_t    q;
      verdict_t v;
      x = vx;
      y = vy;
      if (awaiting_first) begin
        test_x         = px;
        test_y         = py;
        q              = quadrant(x, y);
        first_x        = x;
        first_y        = y;
        first_quad     = q;
        angle          = 0;
        awaiting_first = 1'b0;
      end else begin
        q = quadrant(x, y);
        accumulate(edge_turn(prev_x, prev_y, prev_quad, x, y, q));
      end
      prev_x    = x;
      prev_y    = y;
      prev_quad = q;
      if (last) begin
        accumulate(edge_turn(x, y, q, first_x, first_y, first_quad));
        v.in_poly = (angle == int'(ANGLE_TURN_CC) || angle == int'(ANGLE_TURN_CW));
        v.sum     = angle_t'(angle);
        expected_verdicts = {expected_verdicts, v};
        awaiting_first = 1'b1;
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic in_poly, angle_t sum);
      verdict_t e;
      results_checked++;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("result %0d with no polygon pending: inside=%0b angle=%0d",
                         results_checked, in_poly, sum));
        return;
      end
      e = expected_verdicts.pop_front();
      if (in_poly !== e.in_poly || sum !== e.sum) begin
        report($sformatf("result %0d: expected inside=%0b angle=%0d, got inside=%0b angle=%0d",
                         results_checked, e.in_poly, e.sum, in_poly, sum));
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  coord_t vertex_x_i;
  coord_t vertex_y_i;
  coord_t point_x_i;
  coord_t point_y_i;
  logic   last_vertex_i;
  logic   out_valid_o;
  logic   out_ready_i;
  logic   inside_res_o;
  angle_t angle_sum_o;

  polygon_scoreboard sb = new();
  bit                quiet_tail = 1'b0;
  int                vertices_sent = 0;

  point_in_polygon_quadrant_angle dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .last_vertex_i (last_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .inside_res_o  (inside_res_o),
    .angle_sum_o   (angle_sum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one vertex, with an occasional idle burst ahead of it, and returns
  // at the rising edge where the transfer happens.
  task automatic send_vertex(coord_t vx, coord_t vy, coord_t px, coord_t py, logic last);
    int gap;
    gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    vertex_x_i    <= vx;
    vertex_y_i    <= vy;
    point_x_i     <= px;
    point_y_i     <= py;
    last_vertex_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_vertex(vx, vy, px, py, last);
    vertices_sent++;
  endtask

  function automatic coord_t pick_coord();
    coord_t corner_values[7] = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1,
                                 16'sh7ffe, 16'sh7fff};
    if ($urandom_range(0, 3) == 0) return corner_values[$urandom_range(0, 6)];
    return coord_t'($urandom);
  endfunction

  // Several square turns around the origin wind the angle sum well past one turn.
  task automatic wind_polygon(int turns, bit clockwise);
    int sx, sy;
    for (int t = 0; t < turns; t++) begin
      for (int k = 0; k < 4; k++) begin
        sx = (k == 0 || k == (clockwise ? 1 : 3)) ? 100 : -100;
        sy = (k < 2) ? 100 : -100;
        if (clockwise) sy = (k == 0 || k == 3) ? 100 : -100;
        send_vertex(coord_t'(sx), coord_t'(sy), 0, 0, (t == turns - 1) && (k == 3));
      end
    end
  endtask

  // Most polygons wind around the test point with random radii; the rest are
  // tight clusters that land on edges and vertices, or plain noise.
  task automatic send_random_polygon();
    int     n, kind, seg, r, sx, sy;
    bit     clockwise;
    coord_t px, py, vx, vy, qx, qy;
    kind      = $urandom_range(0, 9);
    clockwise = $urandom_range(0, 1);
    n         = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
    if (kind < 6) begin
      px = coord_t'($urandom_range(0, 32767) - 16384);
      py = coord_t'($urandom_range(0, 32767) - 16384);
    end else begin
      px = pick_coord();
      py = pick_coord();
    end
    for (int k = 0; k < n; k++) begin
      if (kind < 6) begin
        seg = (k * 4) / n;
        if (clockwise) seg = 3 - seg;
        sx  = (seg == 0 || seg == 3) ? 1 : -1;
        sy  = (seg < 2) ? 1 : -1;
        r   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16000);
        vx  = coord_t'(px + sx * r);
        r   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16000);
        vy  = coord_t'(py + sy * r);
      end else if (kind < 8) begin
        vx = coord_t'(px + $urandom_range(0, 8) - 4);
        vy = coord_t'(py + $urandom_range(0, 8) - 4);
      end else begin
        vx = pick_coord();
        vy = pick_coord();
      end
      // The test point only counts on the first vertex; later ones carry junk.
      qx = (k == 0) ? px : coord_t'($urandom);
      qy = (k == 0) ? py : coord_t'($urandom);
      send_vertex(vx, vy, qx, qy, k == n - 1);
    end
  endtask

  // Result side: random short stalls, and one long hold-off once results flow.
  initial begin
    int stall;
    bit held;
    stall = 0;
    held  = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sb.results_checked >= HOLD_AFTER) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !quiet_tail && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 3);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(inside_res_o, angle_sum_o);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    vertex_x_i    = '0;
    vertex_y_i    = '0;
    point_x_i     = '0;
    point_y_i     = '0;
    last_vertex_i = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // A single vertex closes on itself.
    send_vertex(-32768, 32767, 32767, -32768, 1'b1);
    // Square around the origin, counterclockwise.
    send_vertex(10, 10, 0, 0, 1'b0);
    send_vertex(-10, 10, 0, 0, 1'b0);
    send_vertex(-10, -10, 0, 0, 1'b0);
    send_vertex(10, -10, 0, 0, 1'b1);
    // Full-range square, clockwise.
    send_vertex(32767, 32767, -1, -1, 1'b0);
    send_vertex(32767, -32768, 0, 0, 1'b0);
    send_vertex(-32768, -32768, 0, 0, 1'b0);
    send_vertex(-32768, 32767, 0, 0, 1'b1);
    // Test point on a vertex, then on an edge.
    send_vertex(0, 0, 0, 0, 1'b0);
    send_vertex(8, 1, 0, 0, 1'b0);
    send_vertex(1, 8, 0, 0, 1'b1);
    send_vertex(-5, 0, 0, 0, 1'b0);
    send_vertex(5, 0, 0, 0, 1'b0);
    send_vertex(0, 8, 0, 0, 1'b1);
    // Half turns crossing right of the point, then left of it.
    send_vertex(6, 5, 0, 0, 1'b0);
    send_vertex(-4, -5, 0, 0, 1'b0);
    send_vertex(-6, 5, 0, 0, 1'b1);
    send_vertex(4, 5, 0, 0, 1'b0);
    send_vertex(-6, -5, 0, 0, 1'b0);
    send_vertex(6, -5, 0, 0, 1'b1);
    // A diagonal edge runs straight through the test point.
    send_vertex(10, 10, 0, 0, 1'b0);
    send_vertex(-10, -10, 0, 0, 1'b0);
    send_vertex(10, -10, 0, 0, 1'b1);

    while (vertices_sent < 380) send_random_polygon();
    wind_polygon(WIND_TURNS, 1'b0);
    wind_polygon(WIND_TURNS, 1'b1);
    while (vertices_sent < 440) send_random_polygon();

    quiet_tail = 1'b1;
    while (vertices_sent < 500) send_random_polygon();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* point_in_polygon_quadrant_angle.f */
hw/rtl/pipqa_pkg.sv
hw/rtl/pipqa_edge.sv
hw/rtl/pipqa_accum.sv
hw/rtl/point_in_polygon_quadrant_angle.sv
hw/rtl/pipqa_chk.sv
sim/testbench.sv
